@@ hdl/qsss_pkg.sv @@
`timescale 1ns / 1ps
// qsss_pkg: shared types, constants and codes for the quoted span space substitution block
// no dependencies

package qsss_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int NUM_CAND    = 18;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	// substitute candidates in order of preference
	localparam logic [7:0] CAND_TAB [NUM_CAND] = '{
		8'h23, 8'h3f, 8'h2a, 8'h21, 8'h40, 8'h2b, 8'h2d, 8'h3d,
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
	};

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOSUB    = 2'd1;
	localparam status_t ST_NOREGION = 2'd2;
	localparam status_t ST_OVERFLOW = 2'd3;

	typedef enum logic [1:0] {
		S_LOAD,
		S_DECIDE,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan_step;
		logic emit_fail;
		logic flush;
		logic clear;
	} cmd_t;

	typedef struct packed {
		status_t fail;
		logic    out_free;
		logic    scan_done;
	} sts_t;

endpackage

@@ hdl/qsss_ctrl.sv @@
`timescale 1ns / 1ps
// qsss_ctrl: controller state machine for load, decide and scan phases
// depends on qsss_pkg

module qsss_ctrl import qsss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_last) begin
						state_nxt = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				if (sts.fail != ST_OK) begin
					if (sts.out_free) begin
						cmd.emit_fail = 1'b1;
						cmd.clear     = 1'b1;
						state_nxt     = S_LOAD;
					end
				end else begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.out_free) begin
					if (sts.scan_done) begin
						cmd.flush = 1'b1;
						cmd.clear = 1'b1;
						state_nxt = S_LOAD;
					end else begin
						cmd.scan_step = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_LOAD;
			end
		endcase
	end

endmodule

@@ hdl/qsss_dp.sv @@
`timescale 1ns / 1ps
// qsss_dp: string buffer, candidate and quote tracking, scan logic and output register
// depends on qsss_pkg

module qsss_dp import qsss_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic [7:0] char_in,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_char,
	output logic [7:0] out_subst,
	output status_t    out_status,
	output logic       out_end
);

	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);

	logic [7:0]          str_mem [MAX_LEN];
	logic [7:0]          rd_data_s1;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;

	logic [CNT_W-1:0]    fill_q;
	logic [NUM_CAND-1:0] mask_q;
	logic                ovf_q;
	logic [1:0]          sq_cnt_q, dq_cnt_q;
	logic [CNT_W-1:0]    sq_last_q, dq_last_q;
	logic [CNT_W-1:0]    scan_i_q;
	logic                in_reg_q, reg_dq_q;
	logic                pend_valid_q;
	logic [7:0]          pend_char_q;

	logic                out_valid_q, out_end_q;
	logic [7:0]          out_char_q, out_subst_q;
	status_t             out_status_q;

	logic [NUM_CAND-1:0] cand_hit;
	logic [7:0]          sc;
	status_t             fail_code;
	logic                in_sq, in_dq;
	logic                b_sq, b_dq, opens, closes, emit;
	logic [7:0]          emit_char;
	logic                out_load, out_end_nxt;
	logic [7:0]          out_char_nxt, out_subst_nxt;
	status_t             out_status_nxt;

	assign wr_en = cmd.accept && (fill_q < FULL);
	assign in_sq = (char_in == CH_SQUOTE);
	assign in_dq = (char_in == CH_DQUOTE);

	always_comb begin
		for (int k = 0; k < NUM_CAND; k++) begin
			cand_hit[k] = (char_in == CAND_TAB[k]);
		end
	end

	// first candidate not present in the string
	always_comb begin
		sc = 8'h00;
		for (int k = NUM_CAND - 1; k >= 0; k--) begin
			if (!mask_q[k]) begin
				sc = CAND_TAB[k];
			end
		end
	end

	always_comb begin
		if (ovf_q) begin
			fail_code = ST_OVERFLOW;
		end else if (&mask_q) begin
			fail_code = ST_NOSUB;
		end else if (!sq_cnt_q[1] && !dq_cnt_q[1]) begin
			fail_code = ST_NOREGION;
		end else begin
			fail_code = ST_OK;
		end
	end

	assign sts.fail      = fail_code;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.scan_done = (scan_i_q == fill_q);

	// a quote opens a region only if the same quote occurs later
	assign b_sq      = (rd_data_s1 == CH_SQUOTE);
	assign b_dq      = (rd_data_s1 == CH_DQUOTE);
	assign opens     = !in_reg_q && ((b_sq && (scan_i_q < sq_last_q)) ||
	                                 (b_dq && (scan_i_q < dq_last_q)));
	assign closes    = in_reg_q && (reg_dq_q ? b_dq : b_sq);
	assign emit      = !opens && !closes;
	assign emit_char = (in_reg_q && (rd_data_s1 == CH_SPACE)) ? sc : rd_data_s1;

	// re-read the current byte while stalled, prefetch the next one on a step
	assign rd_addr = cmd.scan_step ? IDX_W'(scan_i_q + 1'b1) : scan_i_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			str_mem[fill_q[IDX_W-1:0]] <= char_in;
		end
		rd_data_s1 <= str_mem[rd_addr];
	end

	// one byte is held back so the final item can carry the end mark
	always_comb begin
		out_load       = 1'b0;
		out_char_nxt   = 8'h00;
		out_subst_nxt  = sc;
		out_status_nxt = ST_OK;
		out_end_nxt    = 1'b0;
		if (cmd.emit_fail) begin
			out_load       = 1'b1;
			out_subst_nxt  = 8'h00;
			out_status_nxt = fail_code;
			out_end_nxt    = 1'b1;
		end else if (cmd.flush) begin
			out_load     = 1'b1;
			out_char_nxt = pend_valid_q ? pend_char_q : 8'h00;
			out_end_nxt  = 1'b1;
		end else if (cmd.scan_step && emit && pend_valid_q) begin
			out_load     = 1'b1;
			out_char_nxt = pend_char_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			mask_q       <= '0;
			ovf_q        <= 1'b0;
			sq_cnt_q     <= '0;
			dq_cnt_q     <= '0;
			sq_last_q    <= '0;
			dq_last_q    <= '0;
			scan_i_q     <= '0;
			in_reg_q     <= 1'b0;
			reg_dq_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				fill_q <= fill_q + 1'b1;
				mask_q <= mask_q | cand_hit;
				if (in_sq) begin
					sq_last_q <= fill_q;
					if (!sq_cnt_q[1]) begin
						sq_cnt_q <= sq_cnt_q + 1'b1;
					end
				end
				if (in_dq) begin
					dq_last_q <= fill_q;
					if (!dq_cnt_q[1]) begin
						dq_cnt_q <= dq_cnt_q + 1'b1;
					end
				end
			end else if (cmd.accept) begin
				ovf_q <= 1'b1;
			end
			if (cmd.scan_step) begin
				scan_i_q <= scan_i_q + 1'b1;
				if (opens) begin
					in_reg_q <= 1'b1;
					reg_dq_q <= b_dq;
				end
				if (closes) begin
					in_reg_q <= 1'b0;
				end
				if (emit) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.clear) begin
				fill_q       <= '0;
				mask_q       <= '0;
				ovf_q        <= 1'b0;
				sq_cnt_q     <= '0;
				dq_cnt_q     <= '0;
				sq_last_q    <= '0;
				dq_last_q    <= '0;
				scan_i_q     <= '0;
				in_reg_q     <= 1'b0;
				reg_dq_q     <= 1'b0;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && emit) begin
			pend_char_q <= emit_char;
		end
		if (out_load) begin
			out_char_q   <= out_char_nxt;
			out_subst_q  <= out_subst_nxt;
			out_status_q <= out_status_nxt;
			out_end_q    <= out_end_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign out_subst  = out_subst_q;
	assign out_status = out_status_q;
	assign out_end    = out_end_q;

endmodule

@@ hdl/quoted_span_space_substitution.sv @@
`timescale 1ns / 1ps
// bytes load one per cycle while in the load state; after the last byte a decide state checks
// the string, then the buffer is walked one byte per cycle while the output is free, and a
// closing item ends the result; no new string is taken until its closing or status item is loaded
// a failed string gives its status item from the decide state once the output is free
// reset: asynchronous, active low; clears control state, the buffer needs no clearing
// depends on qsss_pkg, qsss_ctrl, qsss_dp

module quoted_span_space_substitution import qsss_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] char_out, [15:8] subst_char
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast    // end_of_result
);

	cmd_t       cmd;
	sts_t       sts;
	logic [7:0] out_char, out_subst;
	status_t    out_status;

	qsss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qsss_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.char_in    (s_tdata),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_char   (out_char),
		.out_subst  (out_subst),
		.out_status (out_status),
		.out_end    (m_tlast)
	);

	assign m_tdata = {out_subst, out_char};
	assign m_tuser = out_status;

	// a failure item is a single, final item with empty data
	a_fail_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fail |=> m_tvalid && m_tlast && (m_tdata == 16'h0000) &&
			(m_tuser != ST_OK))
		else $error("failure item malformed");

	// the closing item carries a substitute and ok status
	a_flush_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> m_tvalid && m_tlast && (m_tuser == ST_OK) && (m_tdata[15:8] != 8'h00))
		else $error("closing item malformed");

	// no input is taken while the buffer is being walked
	a_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && (cmd.scan_step || cmd.flush)))
		else $error("input accepted during scan");

	// a non-ok status never appears on a non-final item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> m_tlast)
		else $error("error status on non-final item");

endmodule
